// ----- design/accel_window_average_core_defines.svh -----
// Assertion macros for the window average core.
`ifndef ACCEL_WINDOW_AVERAGE_CORE_DEFINES_SVH
`define ACCEL_WINDOW_AVERAGE_CORE_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define AWA_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("awa assertion failed");
// next-cycle implication
`define AWA_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("awa assertion failed");
`else
`define AWA_ASSERT_NOW(label, clk, rst, pre, post)
`define AWA_ASSERT_NEXT(label, clk, rst, pre, post)
`endif

`endif

// ----- design/awa_pkg.sv -----
package awa_pkg;

   // raw sensor byte and formed sample widths
   localparam int RAW_W      = 8;
   localparam int LOW_KEEP   = 6;
   localparam int SAMPLE_W   = RAW_W + LOW_KEEP;
   localparam int AXES       = 3;
   localparam int WINDOW_DEF = 10;

   typedef logic [RAW_W-1:0]           raw_type;
   typedef logic signed [SAMPLE_W-1:0] sample_type;

endpackage

// ----- design/accel_window_average_core.sv -----
// Three-axis accelerometer window average. Each item carries a high and a low
// byte per axis; the core forms a 14-bit signed sample per axis, writes it into
// a WINDOW-deep ring store (cleared at reset, so unwritten slots count as zero)
// and returns the new samples with the windowed mean: the sum of the truncated
// per-sample quotients by WINDOW plus the truncated quotient of the summed
// remainders. One item is accepted every cycle unless the result side stalls;
// each result passes through the input register and then the result register
// (the sample is split into quotient and remainder ahead of the input register,
// and the result stage swaps the oldest slot out of the running sums).
// The result register lets a new item in while an earlier result is stalled.
`include "accel_window_average_core_defines.svh"

module accel_window_average_core #(
   parameter int WINDOW = awa_pkg::WINDOW_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  awa_pkg::raw_type     req_x_high,
   input  awa_pkg::raw_type     req_x_low,
   input  awa_pkg::raw_type     req_y_high,
   input  awa_pkg::raw_type     req_y_low,
   input  awa_pkg::raw_type     req_z_high,
   input  awa_pkg::raw_type     req_z_low,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output awa_pkg::sample_type  rsp_x_now,
   output awa_pkg::sample_type  rsp_y_now,
   output awa_pkg::sample_type  rsp_z_now,
   output awa_pkg::sample_type  rsp_x_mean,
   output awa_pkg::sample_type  rsp_y_mean,
   output awa_pkg::sample_type  rsp_z_mean
);

   localparam int SAMPLE_W = awa_pkg::SAMPLE_W;
   localparam int RAW_W    = awa_pkg::RAW_W;
   localparam int LOW_KEEP = awa_pkg::LOW_KEEP;
   localparam int AXES     = awa_pkg::AXES;
   localparam int SLOT_W   = $clog2(WINDOW);
   localparam int REM_W    = $clog2(WINDOW) + 1;
   localparam int QSUM_W   = SAMPLE_W + 1;
   localparam int RSUM_W   = $clog2(WINDOW * (WINDOW - 1) + 1) + 1;
   localparam int RMAG_W   = RSUM_W - 1;

   // exact reciprocal for sample magnitudes up to 2**(SAMPLE_W-1)
   localparam int DIV_SHIFT = SAMPLE_W + $clog2(WINDOW) + 1;
   localparam int DIV_RW    = DIV_SHIFT + 1;
   localparam int PROD_W    = SAMPLE_W + DIV_RW;
   localparam logic [DIV_RW-1:0] DIV_RECIP = DIV_RW'((2 ** DIV_SHIFT) / WINDOW + 1);

   // exact reciprocal for the remainder-sum magnitude
   localparam int MEAN_SHIFT = RMAG_W + $clog2(WINDOW) + 1;
   localparam int MEAN_RW    = MEAN_SHIFT + 1;
   localparam int MPROD_W    = RMAG_W + MEAN_RW;
   localparam logic [MEAN_RW-1:0] MEAN_RECIP = MEAN_RW'((2 ** MEAN_SHIFT) / WINDOW + 1);

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

   // handshake
   logic out_take;
   logic s1_move;
   logic req_fire;
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;

   // input stage signals and registers
   awa_pkg::raw_type           in_high [AXES];
   awa_pkg::raw_type           in_low  [AXES];
   logic signed [SAMPLE_W-1:0] in_sample [AXES];
   logic [SAMPLE_W-1:0]        in_mag  [AXES];
   logic [PROD_W-1:0]          in_prod [AXES];
   logic [SAMPLE_W-1:0]        in_qmag [AXES];
   logic [REM_W-1:0]           in_rmag [AXES];
   logic signed [SAMPLE_W-1:0] in_q    [AXES];
   logic signed [REM_W-1:0]    in_r    [AXES];

   logic signed [SAMPLE_W-1:0] s1_sample_ff [AXES];
   logic signed [SAMPLE_W-1:0] s1_q_ff      [AXES];
   logic signed [REM_W-1:0]    s1_r_ff      [AXES];

   // ring store of per-slot quotient and remainder, plus running sums
   logic signed [SAMPLE_W-1:0] q_store_ff [AXES][WINDOW];
   logic signed [REM_W-1:0]    r_store_ff [AXES][WINDOW];
   logic signed [QSUM_W-1:0]   qsum_ff [AXES];
   logic signed [QSUM_W-1:0]   qsum_in [AXES];
   logic signed [RSUM_W-1:0]   rsum_ff [AXES];
   logic signed [RSUM_W-1:0]   rsum_in [AXES];
   logic [SLOT_W-1:0]          slot_ff, slot_in;

   // result stage signals and registers
   logic [RMAG_W-1:0]          rs_mag  [AXES];
   logic [MPROD_W-1:0]         rs_prod [AXES];
   logic [RMAG_W-1:0]          rq_mag  [AXES];
   logic signed [RSUM_W-1:0]   rq      [AXES];
   logic signed [SAMPLE_W-1:0] mean_in [AXES];

   logic signed [SAMPLE_W-1:0] now_ff  [AXES];
   logic signed [SAMPLE_W-1:0] mean_ff [AXES];

   assign in_high[0] = req_x_high;
   assign in_low[0]  = req_x_low;
   assign in_high[1] = req_y_high;
   assign in_low[1]  = req_y_low;
   assign in_high[2] = req_z_high;
   assign in_low[2]  = req_z_low;

   // flow control: result register frees the input stage
   assign out_take  = !rsp_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && out_take;
   assign req_ready = !s1_valid_ff || out_take;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // input stage: form sample, split into truncated quotient and remainder
   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         in_sample[a] = $signed({in_high[a], in_low[a][RAW_W-1 -: LOW_KEEP]});
         in_mag[a]    = in_sample[a][SAMPLE_W-1] ? $unsigned(-in_sample[a])
                                                 : $unsigned(in_sample[a]);
         in_prod[a]   = PROD_W'(in_mag[a]) * PROD_W'(DIV_RECIP);
         in_qmag[a]   = SAMPLE_W'(in_prod[a] >> DIV_SHIFT);
         in_rmag[a]   = REM_W'(in_mag[a] - SAMPLE_W'(in_qmag[a] * WINDOW));
         in_q[a]      = in_sample[a][SAMPLE_W-1] ? -$signed(in_qmag[a])
                                                 : $signed(in_qmag[a]);
         in_r[a]      = in_sample[a][SAMPLE_W-1] ? -$signed(in_rmag[a])
                                                 : $signed(in_rmag[a]);
      end
   end

   // result stage: swap oldest slot out of the sums, fold remainders in
   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         qsum_in[a] = qsum_ff[a] + QSUM_W'(s1_q_ff[a]) - QSUM_W'(q_store_ff[a][slot_ff]);
         rsum_in[a] = rsum_ff[a] + RSUM_W'(s1_r_ff[a]) - RSUM_W'(r_store_ff[a][slot_ff]);
         rs_mag[a]  = rsum_in[a][RSUM_W-1] ? RMAG_W'(-rsum_in[a]) : RMAG_W'(rsum_in[a]);
         rs_prod[a] = MPROD_W'(rs_mag[a]) * MPROD_W'(MEAN_RECIP);
         rq_mag[a]  = RMAG_W'(rs_prod[a] >> MEAN_SHIFT);
         rq[a]      = rsum_in[a][RSUM_W-1] ? -$signed({1'b0, rq_mag[a]})
                                           : $signed({1'b0, rq_mag[a]});
         mean_in[a] = SAMPLE_W'(qsum_in[a] + QSUM_W'(rq[a]));
      end
      slot_in = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // window state: store, sums and write pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         for (int a = 0; a < AXES; a++) begin
            qsum_ff[a] <= '0;
            rsum_ff[a] <= '0;
            for (int k = 0; k < WINDOW; k++) begin
               q_store_ff[a][k] <= '0;
               r_store_ff[a][k] <= '0;
            end
         end
      end else if (s1_move) begin
         slot_ff <= slot_in;
         for (int a = 0; a < AXES; a++) begin
            qsum_ff[a]             <= qsum_in[a];
            rsum_ff[a]             <= rsum_in[a];
            q_store_ff[a][slot_ff] <= s1_q_ff[a];
            r_store_ff[a][slot_ff] <= s1_r_ff[a];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         for (int a = 0; a < AXES; a++) begin
            s1_sample_ff[a] <= in_sample[a];
            s1_q_ff[a]      <= in_q[a];
            s1_r_ff[a]      <= in_r[a];
         end
      end
      if (s1_move) begin
         for (int a = 0; a < AXES; a++) begin
            now_ff[a]  <= s1_sample_ff[a];
            mean_ff[a] <= mean_in[a];
         end
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_x_now  = now_ff[0];
   assign rsp_y_now  = now_ff[1];
   assign rsp_z_now  = now_ff[2];
   assign rsp_x_mean = mean_ff[0];
   assign rsp_y_mean = mean_ff[1];
   assign rsp_z_mean = mean_ff[2];

   // checks
   `AWA_ASSERT_NOW(a_slot_range, clock, reset, 1'b1, slot_ff <= LAST_SLOT)
   `AWA_ASSERT_NEXT(a_move_gives_result, clock, reset, s1_move, rsp_valid_ff)
   `AWA_ASSERT_NEXT(a_slot_advance, clock, reset, s1_move && slot_ff != LAST_SLOT, slot_ff == $past(slot_ff) + SLOT_W'(1))

endmodule

// ----- tb/sv/tb_accel_window_average_core.sv -----
`timescale 1ns / 1ps

module tb_accel_window_average_core;

   localparam int WINDOW       = awa_pkg::WINDOW_DEF;
   localparam int AXES         = awa_pkg::AXES;
   localparam int SAMPLE_W     = awa_pkg::SAMPLE_W;
   localparam int LOW_KEEP     = awa_pkg::LOW_KEEP;
   localparam int RANDOM_ITEMS = 530;
   localparam int CYCLE_LIMIT  = 400000;

   // one result item: the samples just stored and the per-axis window mean
   typedef struct {
      awa_pkg::sample_type now_v[AXES];
      awa_pkg::sample_type mean_v[AXES];
   } axis_result_type;

   // Tracks the ring of stored samples and the results each item should give.
   class accel_mean_scoreboard;
      int              store[AXES][WINDOW];
      int              write_slot;
      axis_result_type pending_means[$];
      int              mismatches;
      int              checked;

      function new();
         foreach (store[a, k]) store[a][k] = 0;
         write_slot = 0;
         mismatches = 0;
         checked    = 0;
      endfunction

      // sum of truncated quotients plus truncated quotient of the remainders
      function awa_pkg::sample_type window_mean(int a);
         int q;
         int r;
         q = 0;
         r = 0;
         for (int k = 0; k < WINDOW; k++) begin
            q += store[a][k] / WINDOW;
            r += store[a][k] % WINDOW;
         end
         return awa_pkg::sample_type'(q + r / WINDOW);
      endfunction

      function void note_sample(awa_pkg::raw_type b[2*AXES]);
         axis_result_type     want;
         awa_pkg::sample_type s;
         for (int a = 0; a < AXES; a++) begin
            // low byte bits 1..0 are dropped
            s = awa_pkg::sample_type'({b[2*a], b[2*a+1][7:2]});
            store[a][write_slot] = s;
            want.now_v[a] = s;
         end
         for (int a = 0; a < AXES; a++) want.mean_v[a] = window_mean(a);
         write_slot = (write_slot == WINDOW - 1) ? 0 : write_slot + 1;
         pending_means.push_back(want);
      endfunction

      function void check_result(awa_pkg::sample_type now_v[AXES],
                                 awa_pkg::sample_type mean_v[AXES]);
         axis_result_type want;
         string           tag;
         if (pending_means.size() == 0) begin
            $display("%0t: result item with nothing outstanding (now %0d/%0d/%0d)",
                     $time, now_v[0], now_v[1], now_v[2]);
            mismatches++;
            return;
         end
         want = pending_means.pop_front();
         checked++;
         for (int a = 0; a < AXES; a++) begin
            tag = (a == 0) ? "x" : (a == 1) ? "y" : "z";
            if (now_v[a] !== want.now_v[a]) begin
               $display("%0t: %s_now mismatch, expected %0d, actual %0d",
                        $time, tag, want.now_v[a], now_v[a]);
               mismatches++;
            end
            if (mean_v[a] !== want.mean_v[a]) begin
               $display("%0t: %s_mean mismatch, expected %0d, actual %0d",
                        $time, tag, want.mean_v[a], mean_v[a]);
               mismatches++;
            end
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   awa_pkg::raw_type    req_x_high = '0;
   awa_pkg::raw_type    req_x_low  = '0;
   awa_pkg::raw_type    req_y_high = '0;
   awa_pkg::raw_type    req_y_low  = '0;
   awa_pkg::raw_type    req_z_high = '0;
   awa_pkg::raw_type    req_z_low  = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   awa_pkg::sample_type rsp_x_now;
   awa_pkg::sample_type rsp_y_now;
   awa_pkg::sample_type rsp_z_now;
   awa_pkg::sample_type rsp_x_mean;
   awa_pkg::sample_type rsp_y_mean;
   awa_pkg::sample_type rsp_z_mean;

   accel_mean_scoreboard sb = new();

   awa_pkg::raw_type    item_bytes[2*AXES];
   awa_pkg::sample_type got_now[AXES];
   awa_pkg::sample_type got_mean[AXES];
   bit                  quiet_phase = 1'b0;
   int                  items_sent = 0;
   int                  directed_items = 0;
   int                  stall_cycles = 0;
   int                  cycle_count = 0;
   int                  hold_left = 0;

   accel_window_average_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_x_high (req_x_high),
      .req_x_low  (req_x_low),
      .req_y_high (req_y_high),
      .req_y_low  (req_y_low),
      .req_z_high (req_z_high),
      .req_z_low  (req_z_low),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_x_now  (rsp_x_now),
      .rsp_y_now  (rsp_y_now),
      .rsp_z_now  (rsp_z_now),
      .rsp_x_mean (rsp_x_mean),
      .rsp_y_mean (rsp_y_mean),
      .rsp_z_mean (rsp_z_mean)
   );

   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d items outstanding",
                  cycle_count, sb.pending_means.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // mostly no gap, some short, a few long; none in quiet stretches
   function automatic int pick_gap();
      int r;
      if (quiet_phase) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // split a 14-bit sample into raw bytes, with random ignored low bits
   function automatic void encode_axis(int s, output awa_pkg::raw_type hi,
                                       output awa_pkg::raw_type lo);
      logic [SAMPLE_W-1:0] v;
      v  = s[SAMPLE_W-1:0];
      hi = v[SAMPLE_W-1:LOW_KEEP];
      lo = {v[LOW_KEEP-1:0], 2'($urandom_range(0, 3))};
   endfunction

   // present one item and hold it until taken
   task automatic push_sample(input awa_pkg::raw_type b[2*AXES]);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_x_high <= b[0];
      req_x_low  <= b[1];
      req_y_high <= b[2];
      req_y_low  <= b[3];
      req_z_high <= b[4];
      req_z_low  <= b[5];
      req_valid  <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.note_sample(b);
      items_sent++;
   endtask

   task automatic push_axes(input int xs, input int ys, input int zs);
      encode_axis(xs, item_bytes[0], item_bytes[1]);
      encode_axis(ys, item_bytes[2], item_bytes[3]);
      encode_axis(zs, item_bytes[4], item_bytes[5]);
      push_sample(item_bytes);
   endtask

   // result side: random stalls, always ready in quiet stretches
   initial begin
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
         end else if (quiet_phase) begin
            rsp_ready <= 1'b1;
         end else if (rsp_ready) begin
            hold_left = pick_gap();
            if (hold_left > 0) begin
               rsp_ready <= 1'b0;
               hold_left--;
            end
         end else begin
            rsp_ready <= 1'b1;
            hold_left = $urandom_range(0, 8);
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (rsp_ready) begin
            got_now[0]  = rsp_x_now;
            got_now[1]  = rsp_y_now;
            got_now[2]  = rsp_z_now;
            got_mean[0] = rsp_x_mean;
            got_mean[1] = rsp_y_mean;
            got_mean[2] = rsp_z_mean;
            sb.check_result(got_now, got_mean);
         end else begin
            stall_cycles++;
         end
      end
   end

   initial begin
      int mode;
      int v;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // all zero while the store is still empty
      foreach (item_bytes[j]) item_bytes[j] = '0;
      push_sample(item_bytes);
      // largest, smallest and minus one, with ignored low bits set on x and z
      item_bytes = '{8'h7F, 8'hFF, 8'h80, 8'h00, 8'hFF, 8'hFF};
      push_sample(item_bytes);
      // only ignored bits set, full low field, low field clear under a negative high
      item_bytes = '{8'h00, 8'h03, 8'h00, 8'hFF, 8'hFF, 8'h00};
      push_sample(item_bytes);
      // small values of both signs: remainders of both signs
      push_axes(7, -7, 5);
      // fill the whole window with the extremes on x and y, then wrap past it
      for (int i = 0; i < WINDOW; i++) push_axes(8191, -8192, -9);
      push_axes(-3, 3, -8191);
      push_axes(-3, 3, -8191);
      push_axes(9, -9, 8190);
      directed_items = items_sent;

      // random part; every fourth stretch runs with no idling on either side
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         quiet_phase = ((i / 60) % 4 == 2);
         mode = $urandom_range(0, 99);
         if (mode < 40) begin
            foreach (item_bytes[j]) begin
               item_bytes[j] = awa_pkg::raw_type'($urandom_range(0, 255));
            end
            push_sample(item_bytes);
         end else if (mode < 70) begin
            push_axes($urandom_range(0, 40) - 20, $urandom_range(0, 40) - 20,
                      $urandom_range(0, 40) - 20);
         end else if (mode < 85) begin
            for (int a = 0; a < AXES; a++) begin
               case ($urandom_range(0, 5))
                  0: begin v = -8192; end
                  1: begin v = 8191; end
                  2: begin v = -1; end
                  3: begin v = 0; end
                  4: begin v = 1; end
                  default: begin v = -8191; end
               endcase
               encode_axis(v, item_bytes[2*a], item_bytes[2*a+1]);
            end
            push_sample(item_bytes);
         end else begin
            push_axes($urandom_range(0, 16383) - 8192, $urandom_range(0, 16383) - 8192,
                      $urandom_range(0, 16383) - 8192);
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      quiet_phase = 1'b1;

      // drain, then watch a little longer for stray results
      while (sb.pending_means.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (sb.pending_means.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, sb.pending_means.size());
         sb.mismatches += sb.pending_means.size();
      end
      $display("Sent %0d sensor items (%0d directed, %0d random) through the window",
               items_sent, directed_items, items_sent - directed_items);
      $display("Checked %0d result items, %0d cycles of result back-pressure, %0d mismatches",
               sb.checked, stall_cycles, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+design
design/awa_pkg.sv
design/accel_window_average_core.sv
tb/sv/tb_accel_window_average_core.sv
